### sv/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

	typedef logic [31:0] word_t;

	localparam word_t IV0 = 32'h7380166F;
	localparam word_t IV1 = 32'h4914B2B9;
	localparam word_t IV2 = 32'h172442D7;
	localparam word_t IV3 = 32'hDA8A0600;
	localparam word_t IV4 = 32'hA96F30BC;
	localparam word_t IV5 = 32'h163138AA;
	localparam word_t IV6 = 32'hE38DEE4D;
	localparam word_t IV7 = 32'hB0FB0E4E;
	localparam word_t T_LO = 32'h79CC4519;
	localparam word_t T_HI = 32'h7A879D8A;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
	endfunction

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = IV0;
			3'd1: r = IV1;
			3'd2: r = IV2;
			3'd3: r = IV3;
			3'd4: r = IV4;
			3'd5: r = IV5;
			3'd6: r = IV6;
			default: r = IV7;
		endcase
		return r;
	endfunction

endpackage

### sv/sm3_if.sv
// ----------------------------------------------------------------------------
// sm3_in_if / sm3_out_if
// Valid/ready channels of the SM3 hash engine.
// ----------------------------------------------------------------------------
interface sm3_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sm3_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### sv/sm3_ram.sv
// ----------------------------------------------------------------------------
// sm3_ram
// Generic single-port-write, one-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module sm3_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### sv/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// sm3_hash_engine
// SM3 (256-bit) hash of a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  in  channel: one word per byte (data_byte, byte_present, end_of_message).
//      A word with neither flag set is dropped. end_of_message pads the
//      message (0x80, zeros, 64-bit bit length) and starts the digest.
//  out channel: eight digest words, word_index 0 (most significant) first,
//      last_word on the eighth.
// Timing: a byte word is taken while the engine is idle. A byte
//  closing a 64-byte block adds its compression with the input held off:
//  the block memory is streamed into the schedule line, 64 rounds run
//  at one per cycle, then the result folds into the chain value.
//  An end word adds the padding fill from the block word that takes the pad
//  byte (after that block's compression when the end word's byte closes a
//  block), one or two compressions, then 8 output words at one per cycle
//  while the receiver is ready.
// Reset: chain value returns to the IV, byte count clears; the block memory
//  needs no clearing (each word is written before it is read).
// Stall: while digest words wait, no new input word is taken; the result
//  register holds its word until the receiver takes it.
// ----------------------------------------------------------------------------
module sm3_hash_engine
	import sm3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sm3_in_if.sink    in_ch,
	sm3_out_if.source out_ch
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_RND  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [60:0] byte_total_q;
	word_t       cv_q [8];
	word_t       r_q [8];
	word_t       acc_q;        // word being assembled
	logic        fin_q;        // current block is the final one
	logic        pad2_q;       // another block follows before the length one
	logic [5:0]  cnt_q;        // fill / load index, round index
	logic        ph_q;         // load phase: block memory read data valid
	logic [2:0]  oidx_q;
	logic        ovalid_q;
	word_t       bits_hi_q, bits_lo_q;
	// 16-word sliding schedule: w[j..j+15] kept in a shift line
	word_t       w_q [16];

	// block memory
	logic        bm_we;
	logic [3:0]  bm_waddr, bm_raddr;
	word_t       bm_wdata, bm_rdata;

	sm3_ram #(.Width(32), .Depth(16)) u_blk (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	logic [5:0] pos;
	assign pos = byte_total_q[5:0];

	// byte merge into assembled word
	function automatic word_t merge(input word_t a, input logic [1:0] p, input logic [7:0] b);
		word_t r;
		r = (p == 2'd0) ? 32'd0 : a;
		r[(3 - p) * 8 +: 8] = b;
		return r;
	endfunction

	logic  take;
	word_t acc_n;
	assign in_ch.ready = (state_q == S_IDLE);
	assign take = in_ch.valid && in_ch.ready;
	assign acc_n = merge(acc_q, pos[1:0], in_ch.data_byte);

	// round datapath
	logic  hi;
	word_t t_c, a12, ss1, ss2, ff, gg, tt1, tt2, wnext;
	assign hi    = (cnt_q >= 6'd16);
	assign t_c   = rotl(hi ? T_HI : T_LO, cnt_q[4:0]);
	assign a12   = rotl(r_q[0], 5'd12);
	assign ss1   = rotl(a12 + r_q[4] + t_c, 5'd7);
	assign ss2   = ss1 ^ a12;
	assign ff    = hi ? ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]))
	                  : (r_q[0] ^ r_q[1] ^ r_q[2]);
	assign gg    = hi ? ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]))
	                  : (r_q[4] ^ r_q[5] ^ r_q[6]);
	assign tt1   = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
	assign tt2   = gg + r_q[7] + ss1 + w_q[0];
	assign wnext = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
	               ^ rotl(w_q[3], 5'd7) ^ w_q[10];

	// block memory port control
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = pos[5:2];
		bm_wdata = acc_n;
		bm_raddr = cnt_q[3:0];
		if (state_q == S_IDLE && take && in_ch.byte_present && pos[1:0] == 2'd3) begin
			bm_we = 1'b1;
		end else if (state_q == S_PAD) begin
			bm_we    = 1'b1;
			bm_waddr = cnt_q[3:0];
			bm_wdata = acc_q;
			if (!pad2_q && cnt_q[3:0] == 4'd14) bm_wdata = bits_hi_q;
			if (!pad2_q && cnt_q[3:0] == 4'd15) bm_wdata = bits_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			byte_total_q <= '0;
			cnt_q        <= '0;
			ph_q         <= 1'b0;
			fin_q        <= 1'b0;
			pad2_q       <= 1'b0;
			oidx_q       <= '0;
			ovalid_q     <= 1'b0;
			for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						logic [60:0] tot;
						logic [5:0]  p;
						word_t       a;
						tot = byte_total_q;
						a   = acc_q;
						if (in_ch.byte_present) begin
							a   = acc_n;
							tot = byte_total_q + 61'd1;
						end
						byte_total_q <= tot;
						p            = tot[5:0];
						if (in_ch.end_of_message) begin
							bits_hi_q <= tot[60:29];
							bits_lo_q <= {tot[28:0], 3'b000};
							cnt_q     <= {2'b00, p[5:2]};
							acc_q     <= merge(a, p[1:0], PAD_BYTE);
							if (in_ch.byte_present && pos == 6'd63) begin
								// end byte closes a block: compress it, pad a fresh one
								fin_q   <= 1'b0;
								pad2_q  <= 1'b1;
								state_q <= S_LOAD;
							end else begin
								pad2_q  <= (p > 6'd55);
								state_q <= S_PAD;
							end
						end else begin
							acc_q <= a;
							if (in_ch.byte_present && pos == 6'd63) begin
								fin_q   <= 1'b0;
								cnt_q   <= '0;
								state_q <= S_LOAD;
							end
						end
					end
				end
				S_PAD: begin
					acc_q <= '0;
					if (cnt_q[3:0] == 4'd15) begin
						fin_q   <= !pad2_q;
						cnt_q   <= '0;
						state_q <= S_LOAD;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_LOAD: begin
					// registered read: data for address cnt-1 arrives now
					if (ph_q) begin
						for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
						w_q[15] <= bm_rdata;
					end
					ph_q <= 1'b1;
					if (cnt_q == 6'd16) begin
						cnt_q <= '0;
						ph_q  <= 1'b0;
						for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_RND: begin
					r_q[3] <= r_q[2];
					r_q[2] <= rotl(r_q[1], 5'd9);
					r_q[1] <= r_q[0];
					r_q[0] <= tt1;
					r_q[7] <= r_q[6];
					r_q[6] <= rotl(r_q[5], 5'd19);
					r_q[5] <= r_q[4];
					r_q[4] <= perm0(tt2);
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
					w_q[15] <= wnext;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_FIN;
				end
				S_FIN: begin
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ r_q[i];
					cnt_q <= '0;
					if (fin_q) begin
						oidx_q   <= '0;
						ovalid_q <= 1'b1;
						state_q  <= S_OUT;
					end else if (pad2_q) begin
						pad2_q  <= 1'b0;
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							ovalid_q     <= 1'b0;
							byte_total_q <= '0;
							for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.digest_word = cv_q[oidx_q];
	assign out_ch.word_index  = oidx_q;
	assign out_ch.last_word   = (oidx_q == 3'd7);
endmodule
